FILE: rtl/asp_pkg.sv
// Shared types and fixed-point constants for the airfoil surface point pipeline.
`default_nettype none

package asp_pkg;

    // Q30 constants
    localparam logic [30:0] ONE30  = 31'h4000_0000;
    localparam logic [31:0] PI30   = 32'd3373259426;
    localparam logic [30:0] XTE30  = 31'd1083330780;
    localparam logic [31:0] RND30  = 32'h2000_0000;

    // Half-thickness coefficients, 5 * 0.12 folded in, Q30
    localparam logic [27:0] C_SQRT = 28'd191276369;
    localparam logic [27:0] C_LIN  = 28'd81174882;
    localparam logic [27:0] C_SQR  = 28'd226516575;
    localparam logic [27:0] C_CUB  = 28'd183158880;
    localparam logic [27:0] C_QUA  = 28'd65390877;

    // Perimeter parameter limits, Q1.16
    localparam logic [16:0] S_ONE  = 17'd65536;
    localparam logic [16:0] S_HALF = 17'd32768;

    // Reciprocals for exact floor division of a 32-bit value by the Horner
    // divisors: q = (n * M) >> K, M = ceil(2^K / d), K = 32 + ceil(log2 d).
    localparam logic [63:0] M132_W = ((64'd1 << 40) + 64'd131) / 64'd132;
    localparam logic [63:0] M90_W  = ((64'd1 << 39) + 64'd89) / 64'd90;
    localparam logic [63:0] M56_W  = ((64'd1 << 38) + 64'd55) / 64'd56;
    localparam logic [63:0] M30_W  = ((64'd1 << 37) + 64'd29) / 64'd30;
    localparam logic [63:0] M12_W  = ((64'd1 << 36) + 64'd11) / 64'd12;

    localparam int unsigned HORNER_STEPS = 5;

    localparam logic [32:0] DIV_M [HORNER_STEPS] = '{
        M132_W[32:0], M90_W[32:0], M56_W[32:0], M30_W[32:0], M12_W[32:0]
    };
    localparam int unsigned DIV_K [HORNER_STEPS] = '{40, 39, 38, 37, 36};

    // Square root: one result bit per stage
    localparam int unsigned SQRT_STAGES = 31;

    typedef struct packed {
        logic valid;
        logic upper;
    } asp_ctl_t;

    typedef struct packed {
        logic        valid;
        logic        upper;
        logic [20:0] x20;
    } asp_tag_t;

endpackage

`default_nettype wire

FILE: rtl/airfoil_surface_point.sv
// Top level: perimeter parameter to airfoil surface point, fully pipelined.
//
//  channel  | ports                              | handshake
//  ---------+------------------------------------+------------------------------
//  input    | perimeter_pos[16:0]                | start & !busy at rising edge
//  result   | point_x[20:0] point_y[17:0] on_upper | done high for one cycle
//
// A word is taken every cycle; busy never rises. Each result passes through
// the pipeline: 17 stages for the angle, Horner cosine and x scaling, 31
// stages for the square root (one result bit per stage), 7 stages for
// thickness and output.
// rst_n clears all valid bits and the tags riding with them at once;
// the arithmetic registers are not reset.
// The receiver cannot hold results off, so nothing in the pipe ever stalls.
`default_nettype none

module airfoil_surface_point
    import asp_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic        [16:0] perimeter_pos,
    output logic                    done,
    output logic             [20:0] point_x,
    output logic signed      [17:0] point_y,
    output logic                    on_upper
);

    localparam int unsigned LATENCY = 55;

    asp_tag_t    cos_tag;
    asp_tag_t    sqrt_tag;
    logic [30:0] sqrt_val;
    logic        accept;

    // Every cycle is open for a new word
    assign busy   = 1'b0;
    assign accept = start & ~busy;

    // Fold s, build the angle, run the cosine and scale to x
    asp_cos u_cos (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (accept),
        .perimeter_pos (perimeter_pos),
        .tag_out       (cos_tag)
    );

    // sqrt(x) in Q30 while x rides along
    asp_sqrt u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .tag_in  (cos_tag),
        .tag_out (sqrt_tag),
        .sq      (sqrt_val)
    );

    // Polynomial, sign and output word
    asp_thick u_thick (
        .clk      (clk),
        .rst_n    (rst_n),
        .tag_in   (sqrt_tag),
        .sq       (sqrt_val),
        .done     (done),
        .point_x  (point_x),
        .point_y  (point_y),
        .on_upper (on_upper)
    );

    // Every taken word comes out exactly once, after the fixed depth
    a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY done)
        else $error("result missing after pipeline depth");

    a_latency_bwd: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LATENCY))
        else $error("result without a taken word");

    a_x_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> point_x <= 21'd1057941)
        else $error("point_x beyond trailing edge");

endmodule

`default_nettype wire

FILE: rtl/asp_cos.sv
// Chordwise pipeline: parameter fold, angle, Horner cosine, cos^2 and x scaling.
`default_nettype none

module asp_cos
    import asp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic [16:0] perimeter_pos,
    output asp_tag_t         tag_out
);

    logic [16:0] s_clamp;
    logic        s_upper;
    logic [16:0] r_full;

    asp_ctl_t    c0_reg, c1_reg, c2_reg;
    logic [15:0] r0_reg;
    logic [30:0] theta1_reg;
    logic [31:0] z2_reg;

    logic [47:0] theta_prod;
    logic [48:0] theta_sum;
    logic [61:0] z_prod;
    logic [62:0] z_sum;

    // Horner chain: one divide stage and one multiply stage per step
    asp_ctl_t    cd_reg [HORNER_STEPS];
    asp_ctl_t    cp_reg [HORNER_STEPS];
    logic [31:0] zd_reg [HORNER_STEPS];
    logic [31:0] zp_reg [HORNER_STEPS];
    logic [31:0] q_reg  [HORNER_STEPS];
    logic [31:0] p_reg  [HORNER_STEPS];

    asp_ctl_t    cc_reg, cq_reg, cx_reg;
    logic [30:0] c_reg, cos2_reg, x30_reg;
    logic [30:0] a_w, c_next;
    logic [61:0] cos2_prod, x30_prod;
    logic [62:0] cos2_sum, x30_sum;
    logic [31:0] x20_sum;
    asp_tag_t    tag_reg;

    // Fold the parameter onto the quarter turn
    always_comb
    begin
        s_clamp = (perimeter_pos > S_ONE) ? S_ONE : perimeter_pos;
        s_upper = (s_clamp <= S_HALF);
        r_full  = s_upper ? s_clamp : (S_ONE - s_clamp);
    end

    assign theta_prod = 48'(PI30) * 48'(r0_reg);
    assign theta_sum  = 49'(theta_prod) + 49'd32768;
    assign z_prod     = 62'(theta1_reg) * 62'(theta1_reg);
    assign z_sum      = 63'(z_prod) + 63'(RND30);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c0_reg <= '0;
            c1_reg <= '0;
            c2_reg <= '0;
        end
        else
        begin
            c0_reg <= '{valid: in_valid, upper: s_upper};
            c1_reg <= c0_reg;
            c2_reg <= c1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        r0_reg     <= r_full[15:0];
        theta1_reg <= theta_sum[46:16];
        z2_reg     <= z_sum[61:30];
    end

    for (genvar j = 0; j < HORNER_STEPS; j++)
    begin : g_horner
        logic [31:0] n_w, z_w;
        asp_ctl_t    c_w;
        logic [71:0] dprod;
        logic [30:0] h_w;
        logic [62:0] mprod;

        if (j == 0)
        begin : g_first
            assign n_w = z2_reg;
            assign z_w = z2_reg;
            assign c_w = c2_reg;
        end
        else
        begin : g_next
            assign n_w = p_reg[j-1];
            assign z_w = zp_reg[j-1];
            assign c_w = cp_reg[j-1];
        end

        // Exact floor division by reciprocal multiply
        assign dprod = 72'(n_w) * 72'(DIV_M[j]);
        assign h_w   = ONE30 - q_reg[j][30:0];
        assign mprod = 63'(zd_reg[j]) * 63'(h_w);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                cd_reg[j] <= '0;
                cp_reg[j] <= '0;
            end
            else
            begin
                cd_reg[j] <= c_w;
                cp_reg[j] <= cd_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            q_reg[j]  <= dprod[DIV_K[j] +: 32];
            zd_reg[j] <= z_w;
            p_reg[j]  <= mprod[61:30];
            zp_reg[j] <= zd_reg[j];
        end
    end

    // Last Horner term halves; clamp a cosine that rounds below zero
    assign a_w       = p_reg[HORNER_STEPS-1][31:1];
    assign c_next    = (a_w > ONE30) ? '0 : (ONE30 - a_w);
    assign cos2_prod = 62'(c_reg) * 62'(c_reg);
    assign cos2_sum  = 63'(cos2_prod) + 63'(RND30);
    assign x30_prod  = 62'(XTE30) * 62'(cos2_reg);
    assign x30_sum   = 63'(x30_prod) + 63'(RND30);
    assign x20_sum   = 32'(x30_reg) + 32'd512;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cc_reg  <= '0;
            cq_reg  <= '0;
            cx_reg  <= '0;
            tag_reg <= '0;
        end
        else
        begin
            cc_reg  <= cp_reg[HORNER_STEPS-1];
            cq_reg  <= cc_reg;
            cx_reg  <= cq_reg;
            tag_reg <= '{valid: cx_reg.valid, upper: cx_reg.upper, x20: x20_sum[30:10]};
        end
    end

    always_ff @(posedge clk)
    begin
        c_reg    <= c_next;
        cos2_reg <= cos2_sum[60:30];
        x30_reg  <= x30_sum[60:30];
    end

    assign tag_out = tag_reg;

endmodule

`default_nettype wire

FILE: rtl/asp_sqrt.sv
// Pipelined digit-by-digit square root of x scaled to Q60, one result bit per stage.
`default_nettype none

module asp_sqrt
    import asp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  asp_tag_t         tag_in,
    output asp_tag_t         tag_out,
    output logic [30:0]      sq
);

    asp_tag_t    t_reg   [SQRT_STAGES];
    logic [31:0] rem_reg [SQRT_STAGES];
    logic [30:0] res_reg [SQRT_STAGES];

    for (genvar i = 0; i < SQRT_STAGES; i++)
    begin : g_bit
        asp_tag_t    t_w;
        logic [31:0] rem_w;
        logic [30:0] res_w;
        logic [61:0] n_w;
        logic [33:0] cur;
        logic [33:0] trial;
        logic        fits;

        if (i == 0)
        begin : g_first
            assign t_w   = tag_in;
            assign rem_w = '0;
            assign res_w = '0;
        end
        else
        begin : g_next
            assign t_w   = t_reg[i-1];
            assign rem_w = rem_reg[i-1];
            assign res_w = res_reg[i-1];
        end

        // Radicand is x20 << 40; bring down two bits per stage
        assign n_w   = {1'b0, t_w.x20, 40'd0};
        assign cur   = {rem_w, n_w[61-2*i -: 2]};
        assign trial = {1'b0, res_w, 2'b01};
        assign fits  = (cur >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                t_reg[i] <= '0;
            end
            else
            begin
                t_reg[i] <= t_w;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[i] <= fits ? 32'(cur - trial) : cur[31:0];
            res_reg[i] <= {res_w[29:0], fits};
        end
    end

    assign tag_out = t_reg[SQRT_STAGES-1];
    assign sq      = res_reg[SQRT_STAGES-1];

endmodule

`default_nettype wire

FILE: rtl/asp_thick.sv
// Thickness pipeline: powers of x, coefficient terms, signed sum and output word.
`default_nettype none

module asp_thick
    import asp_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  asp_tag_t                tag_in,
    input  wire logic        [30:0] sq,
    output logic                    done,
    output logic             [20:0] point_x,
    output logic signed      [17:0] point_y,
    output logic                    on_upper
);

    asp_tag_t    t1_reg, t2_reg, t3_reg, t4_reg, t5_reg, t6_reg;
    logic [30:0] xv1_reg, xv2_reg, xv3_reg;
    logic [30:0] sq1_reg, sq2_reg, sq3_reg;
    logic [30:0] x2_1_reg, x2_2_reg, x2_3_reg;
    logic [30:0] x3_2_reg, x3_3_reg;
    logic [30:0] x4_3_reg;
    logic [29:0] t_sq_reg, t_lin_reg, t_sqr_reg, t_cub_reg, t_qua_reg;
    logic [30:0] pos_reg;
    logic [31:0] neg_reg;
    logic [31:0] mag_reg;
    logic        neg_th_reg;

    logic        done_reg, upper_reg;
    logic [20:0] x_reg;
    logic [17:0] y_reg;

    logic [30:0] xv_w;
    logic [61:0] x2_prod, x3_prod, x4_prod;
    logic [58:0] p_sq, p_lin, p_sqr, p_cub, p_qua;
    logic [31:0] mag_w;
    logic [17:0] mag20_w;
    logic        flip_w;

    function automatic logic [30:0] rnd62(input logic [61:0] p);
        logic [62:0] s;
        s = 63'(p) + 63'(RND30);
        return s[60:30];
    endfunction

    function automatic logic [29:0] rnd59(input logic [58:0] p);
        logic [59:0] s;
        s = 60'(p) + 60'(RND30);
        return s[59:30];
    endfunction

    assign xv_w    = {tag_in.x20, 10'd0};
    assign x2_prod = 62'(xv_w) * 62'(xv_w);
    assign x3_prod = 62'(x2_1_reg) * 62'(xv1_reg);
    assign x4_prod = 62'(x3_2_reg) * 62'(xv2_reg);

    assign p_sq  = 59'(C_SQRT) * 59'(sq3_reg);
    assign p_lin = 59'(C_LIN)  * 59'(xv3_reg);
    assign p_sqr = 59'(C_SQR)  * 59'(x2_3_reg);
    assign p_cub = 59'(C_CUB)  * 59'(x3_3_reg);
    assign p_qua = 59'(C_QUA)  * 59'(x4_3_reg);

    assign mag_w   = 32'(mag_reg + 32'd512);
    assign mag20_w = mag_w[27:10];
    // Lower surface flips the sign; a negative thickness flips it again
    assign flip_w  = neg_th_reg != !t6_reg.upper;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_reg    <= '0;
            t2_reg    <= '0;
            t3_reg    <= '0;
            t4_reg    <= '0;
            t5_reg    <= '0;
            t6_reg    <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            t1_reg    <= tag_in;
            t2_reg    <= t1_reg;
            t3_reg    <= t2_reg;
            t4_reg    <= t3_reg;
            t5_reg    <= t4_reg;
            t6_reg    <= t5_reg;
            done_reg  <= t6_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        xv1_reg    <= xv_w;
        sq1_reg    <= sq;
        x2_1_reg   <= rnd62(x2_prod);

        xv2_reg    <= xv1_reg;
        sq2_reg    <= sq1_reg;
        x2_2_reg   <= x2_1_reg;
        x3_2_reg   <= rnd62(x3_prod);

        xv3_reg    <= xv2_reg;
        sq3_reg    <= sq2_reg;
        x2_3_reg   <= x2_2_reg;
        x3_3_reg   <= x3_2_reg;
        x4_3_reg   <= rnd62(x4_prod);

        t_sq_reg   <= rnd59(p_sq);
        t_lin_reg  <= rnd59(p_lin);
        t_sqr_reg  <= rnd59(p_sqr);
        t_cub_reg  <= rnd59(p_cub);
        t_qua_reg  <= rnd59(p_qua);

        pos_reg    <= 31'(t_sq_reg) + 31'(t_cub_reg);
        neg_reg    <= 32'(t_lin_reg) + 32'(t_sqr_reg) + 32'(t_qua_reg);

        neg_th_reg <= 32'(pos_reg) < neg_reg;
        mag_reg    <= (32'(pos_reg) >= neg_reg) ? (32'(pos_reg) - neg_reg)
                                                : (neg_reg - 32'(pos_reg));

        x_reg      <= t6_reg.x20;
        upper_reg  <= t6_reg.upper;
        y_reg      <= flip_w ? (18'd0 - mag20_w) : mag20_w;
    end

    assign done     = done_reg;
    assign point_x  = x_reg;
    assign point_y  = signed'(y_reg);
    assign on_upper = upper_reg;

endmodule

`default_nettype wire
